### src/qat_pkg.sv
// qat_pkg: shared types and constants for the quoted argument tokenizer.
// No dependencies; imported by qat_scan, qat_outq and quoted_argument_tokenizer.
package qat_pkg;

	localparam int unsigned QAT_MAX_TOKENS = 16;
	localparam int unsigned QAT_Q_DEPTH    = 8;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	localparam logic [1:0] KIND_CHAR      = 2'd0;
	localparam logic [1:0] KIND_TOKEN_END = 2'd1;
	localparam logic [1:0] KIND_LINE_END  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_char;
		logic [3:0] token_index;
		logic [4:0] token_count;
		logic       last;
	} res_t;

	// up to two results from one input beat
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} pair_t;

endpackage

### src/qat_char_if.sv
// qat_char_if: input channel, one line character or line end per beat.
// Depends on nothing.
interface qat_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       line_end;

	modport source (output valid, output ch, output line_end, input ready);
	modport sink (input valid, input ch, input line_end, output ready);
endinterface

### src/qat_tok_if.sv
// qat_tok_if: result channel, one token character, token end or line end per beat.
// Depends on nothing.
interface qat_tok_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic [3:0] token_index;
	logic [4:0] token_count;
	logic       last;

	modport source (output valid, output kind, output out_char, output token_index,
		output token_count, output last, input ready);
	modport sink (input valid, input kind, input out_char, input token_index,
		input token_count, input last, output ready);
endinterface

### src/qat_scan.sv
// qat_scan: scan mode and token count, builds up to two results per beat.
// Depends on qat_pkg and qat_char_if; results leave in a registered pair.
module qat_scan #(
	parameter int unsigned MAX_TOKENS = qat_pkg::QAT_MAX_TOKENS
) (
	input  logic            clk,
	input  logic            arst_n,
	qat_char_if.sink        chars,
	input  logic            room,
	output qat_pkg::pair_t  pair_s1
);
	import qat_pkg::*;

	localparam int unsigned CW = $clog2(MAX_TOKENS + 1);

	typedef enum logic [1:0] {
		MODE_BETWEEN,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_ESCAPE
	} mode_t;

	mode_t          mode_q, mode_d;
	logic [CW-1:0]  seen_q, seen_d;
	logic           take, full, sep, emit_chr, emit_end;
	logic [7:0]     cur_w, nxt_w;
	res_t           char_r, end_r, eol_r;
	pair_t          pair_d;
	logic [1:0]     n_s1;
	res_t           r0_s1, r1_s1;

	assign chars.ready = room;
	assign take        = chars.valid & room;

	always_comb begin
		full  = (seen_q == CW'(MAX_TOKENS));
		sep   = chars.ch inside {CH_SPACE, CH_TAB};
		cur_w = 8'(seen_q);
		nxt_w = 8'(seen_q + 1'b1);

		char_r = '{kind: KIND_CHAR, out_char: chars.ch, token_index: cur_w[3:0],
			token_count: cur_w[4:0], last: 1'b0};
		end_r  = '{kind: KIND_TOKEN_END, out_char: 8'd0, token_index: cur_w[3:0],
			token_count: nxt_w[4:0], last: 1'b0};
		eol_r  = '{kind: KIND_LINE_END, out_char: 8'd0, token_index: 4'd0,
			token_count: cur_w[4:0], last: 1'b0};

		mode_d   = mode_q;
		seen_d   = seen_q;
		emit_chr = 1'b0;
		emit_end = 1'b0;
		pair_d   = '0;

		if (chars.line_end) begin
			mode_d = MODE_BETWEEN;
			seen_d = '0;
			if (mode_q != MODE_BETWEEN && !full) begin
				eol_r.token_count = nxt_w[4:0];
				pair_d.r0 = end_r;
				pair_d.r1 = eol_r;
				pair_d.n  = 2'd2;
			end else begin
				pair_d.r0 = eol_r;
				pair_d.n  = 2'd1;
			end
		end else begin
			case (mode_q)
				MODE_BETWEEN: begin
					if (sep) begin
						mode_d = MODE_BETWEEN;
					end else if (chars.ch == CH_QUOTE) begin
						mode_d = MODE_QUOTED;
					end else begin
						mode_d   = MODE_PLAIN;
						emit_chr = 1'b1;
					end
				end
				MODE_PLAIN: begin
					if (sep) begin
						mode_d   = MODE_BETWEEN;
						emit_end = 1'b1;
					end else begin
						emit_chr = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (chars.ch == CH_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else if (chars.ch == CH_QUOTE) begin
						mode_d   = MODE_BETWEEN;
						emit_end = 1'b1;
					end else begin
						emit_chr = 1'b1;
					end
				end
				MODE_ESCAPE: begin
					mode_d   = MODE_QUOTED;
					emit_chr = 1'b1;
				end
				default: begin
					mode_d = MODE_BETWEEN;
				end
			endcase
			// tokens past the limit are parsed but give no results
			if (emit_chr && !full) begin
				pair_d.r0 = char_r;
				pair_d.n  = 2'd1;
			end
			if (emit_end && !full) begin
				pair_d.r0 = end_r;
				pair_d.n  = 2'd1;
				seen_d    = seen_q + 1'b1;
			end
		end

		if (pair_d.n == 2'd1) begin
			pair_d.r0.last = 1'b1;
		end
		if (pair_d.n == 2'd2) begin
			pair_d.r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			seen_q <= '0;
			n_s1   <= 2'd0;
		end else begin
			n_s1 <= take ? pair_d.n : 2'd0;
			if (take) begin
				mode_q <= mode_d;
				seen_q <= seen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			r0_s1 <= pair_d.r0;
			r1_s1 <= pair_d.r1;
		end
	end

	assign pair_s1 = '{n: n_s1, r0: r0_s1, r1: r1_s1};

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CW'(MAX_TOKENS))
		else $error("token count above limit");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && chars.line_end |=> seen_q == '0 && mode_q == MODE_BETWEEN)
		else $error("line end did not clear scan state");

	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && chars.line_end |=>
		(n_s1 == 2'd1 && r0_s1.kind == KIND_LINE_END && r0_s1.last) ||
		(n_s1 == 2'd2 && r1_s1.kind == KIND_LINE_END && r1_s1.last &&
			r0_s1.kind == KIND_TOKEN_END))
		else $error("line end beat without closing line-end result");

	a_pair_n: assert property (@(posedge clk) disable iff (!arst_n)
		n_s1 != 2'd3)
		else $error("more than two results from one beat");

endmodule

### src/qat_outq.sv
// qat_outq: result queue, takes up to two results a cycle, hands out one while the output is ready.
// Depends on qat_pkg and qat_tok_if; DEPTH must be a power of two, at least 4.
module qat_outq #(
	parameter int unsigned DEPTH = qat_pkg::QAT_Q_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  qat_pkg::pair_t  pair_s1,
	output logic            room,
	qat_tok_if.source       tokens
);
	import qat_pkg::*;

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned CNW = $clog2(DEPTH + 1);
	localparam logic [CNW:0] ROOM_LIMIT = (CNW + 1)'(DEPTH - 2);

	res_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CNW-1:0]  count_q;
	logic            pop;
	res_t            head;

	assign pop  = tokens.valid & tokens.ready;
	// room for a full pair behind whatever is still on its way in
	assign room = ((CNW + 1)'(count_q) + (CNW + 1)'(pair_s1.n)) <= ROOM_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(pair_s1.n);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + CNW'(pair_s1.n) - CNW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pair_s1.n != 2'd0) begin
			mem_q[wr_q] <= pair_s1.r0;
		end
		if (pair_s1.n == 2'd2) begin
			mem_q[wr_q + AW'(1)] <= pair_s1.r1;
		end
	end

	assign head               = mem_q[rd_q];
	assign tokens.valid       = (count_q != '0);
	assign tokens.kind        = head.kind;
	assign tokens.out_char    = head.out_char;
	assign tokens.token_index = head.token_index;
	assign tokens.token_count = head.token_count;
	assign tokens.last        = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(DEPTH))
		else $error("queue occupancy above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		((CNW + 1)'(count_q) + (CNW + 1)'(pair_s1.n)) <= (CNW + 1)'(DEPTH))
		else $error("queue written past full");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pair_s1.n == 2'd0 |=> count_q == $past(count_q) - CNW'(1))
		else $error("queue count did not follow a lone pop");

endmodule

### src/quoted_argument_tokenizer.sv
// quoted_argument_tokenizer: splits a command line into tokens, quotes honoured.
// An accepted beat's results pass the scan's registered pair, then the queue.
// Throughput: one input beat per cycle while the queue has room; results leave
// at one per cycle while the output is ready; a line end that closes a token
// gives two results. The output queue depth sets how far input runs ahead of a stalled output.
// Reset (arst_n low, asynchronous): scan mode, token count and queue cleared.
module quoted_argument_tokenizer #(
	parameter int unsigned MAX_TOKENS = qat_pkg::QAT_MAX_TOKENS,
	parameter int unsigned Q_DEPTH    = qat_pkg::QAT_Q_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	qat_char_if.sink  chars,
	qat_tok_if.source tokens
);
	import qat_pkg::*;

	pair_t pair_s1;
	logic  room;

	qat_scan #(
		.MAX_TOKENS (MAX_TOKENS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.room    (room),
		.pair_s1 (pair_s1)
	);

	qat_outq #(
		.DEPTH (Q_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair_s1 (pair_s1),
		.room    (room),
		.tokens  (tokens)
	);

endmodule
